/* rtl/core/vnd_pkg.sv */
package vnd_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 262144;
  localparam int unsigned TABLE_INDEX_BITS_DEF = 6;

  localparam int unsigned LEN_W = 19;
  localparam logic [LEN_W-1:0] LEN_MAX = 19'h7FFFF;
  localparam logic [LEN_W-1:0] HDR_BYTES = 19'd28;
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  localparam logic [4:0] NAL_IDR = 5'd5;
  localparam logic [7:0] SLOT_NONE = 8'hFF;
  localparam logic [2:0] KEY_CNT_MAX = 3'd7;
  localparam logic [2:0] KEY_CNT_EMIT = 3'd5;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_REPLAY = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [1:0] CFG_HASH_EN = 2'd0;
  localparam logic [1:0] CFG_HASH_KEY_ONLY = 2'd1;
  localparam logic [1:0] CFG_INJECT_EN = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] slot;
    logic prepend_headers;
    logic is_keyframe;
    logic [LEN_W-1:0] packet_length;
    logic [31:0] hash_value;
  } result_t;

  // summary of one finished packet or connect word handed from front to back
  typedef struct packed {
    logic connect;
    logic is_short;
    logic is_keyframe;
    logic [LEN_W-1:0] byte_count;
    logic [31:0] hash_value;
  } pkt_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* rtl/core/vnd_if.sv */
interface vnd_in_if;
  logic valid;
  logic ready;
  logic action;
  logic [7:0] data_byte;
  logic last;
  modport source(output valid, action, data_byte, last, input ready);
  modport sink(input valid, action, data_byte, last, output ready);
endinterface

interface vnd_out_if;
  logic valid;
  logic ready;
  logic [1:0] kind;
  logic [7:0] slot;
  logic prepend_headers;
  logic is_keyframe;
  logic [18:0] packet_length;
  logic [31:0] hash_value;
  modport source(output valid, kind, slot, prepend_headers, is_keyframe, packet_length,
                 hash_value, input ready);
  modport sink(input valid, kind, slot, prepend_headers, is_keyframe, packet_length,
               hash_value, output ready);
endinterface

/* rtl/core/vnd_front.sv */
module vnd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_action,
  input  logic [7:0]    in_data_byte,
  input  logic          in_last,
  output logic          pkt_valid,
  input  logic          pkt_ready,
  output vnd_pkg::pkt_t pkt
);

  logic [31:0] crc_r, crc_nxt;
  logic [vnd_pkg::LEN_W-1:0] cnt_r, cnt_nxt;
  logic [4:0] nal_r, nal_nxt;
  logic take;

  assign in_ready = pkt_ready;
  assign take = in_valid && pkt_ready;

  always_comb begin
    crc_nxt = vnd_pkg::crc_byte(crc_r, in_data_byte);
    cnt_nxt = (cnt_r < vnd_pkg::LEN_MAX) ? cnt_r + 1'b1 : cnt_r;
    nal_nxt = (cnt_r == 19'd4) ? in_data_byte[4:0] : nal_r;
  end

  assign pkt_valid = take && (in_action || in_last);
  always_comb begin
    pkt.connect = in_action;
    pkt.is_short = cnt_nxt <= 19'd4;
    pkt.is_keyframe = (nal_nxt == vnd_pkg::NAL_IDR);
    pkt.byte_count = cnt_nxt;
    pkt.hash_value = ~crc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= vnd_pkg::CRC_INIT;
      cnt_r <= '0;
      nal_r <= '0;
    end else if (take) begin
      if (in_action || in_last) begin
        crc_r <= vnd_pkg::CRC_INIT;
        cnt_r <= '0;
        nal_r <= '0;
      end else begin
        crc_r <= crc_nxt;
        cnt_r <= cnt_nxt;
        nal_r <= nal_nxt;
      end
    end
  end

endmodule

/* rtl/core/vnd_queue.sv */
module vnd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  vnd_pkg::pkt_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output vnd_pkg::pkt_t rd_data
);

  vnd_pkg::pkt_t mem_r [2];
  logic [1:0] wp_r, rp_r;

  assign wr_ready = (wp_r - rp_r) != 2'd2;
  assign rd_valid = wp_r != rp_r;
  assign rd_data = mem_r[rp_r[0]];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem_r[wp_r[0]] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= wp_r + 2'd1;
      if (rd_valid && rd_ready) rp_r <= rp_r + 2'd1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (wp_r - rp_r) <= 2'd2) else $error("queue count out of range");
  a_empty_no_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (wp_r == rp_r) |-> !rd_valid) else $error("valid on empty queue");
  a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
    ((wp_r - rp_r) == 2'd2) |-> !wr_ready) else $error("write into full queue");

endmodule

/* rtl/core/vnd_back.sv */
module vnd_back #(
  parameter int unsigned BUFFER_BYTES = vnd_pkg::BUFFER_BYTES_DEF,
  parameter int unsigned TABLE_INDEX_BITS = vnd_pkg::TABLE_INDEX_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             hash_en,
  input  logic             hash_key_only,
  input  logic             inject_en,
  input  logic             pkt_valid,
  output logic             pkt_ready,
  input  vnd_pkg::pkt_t    pkt,
  output logic             res_valid,
  input  logic             res_ready,
  output vnd_pkg::result_t res
);

  localparam int unsigned DEPTH = 1 << TABLE_INDEX_BITS;
  localparam logic [24:0] BUF = 25'(BUFFER_BYTES);

  // table with per-entry valid bits; invalid entry reads as zero
  logic [31:0] tbl_r [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [2:0] kcnt_r, kcnt_nxt;
  logic force_r, force_nxt;
  logic res_valid_r;
  vnd_pkg::result_t res_r, res_nxt;
  // lookup stage: packet word plus the table word read for it
  logic s_valid_r;
  vnd_pkg::pkt_t s_pkt_r;
  logic [31:0] rd_r;
  logic fwd_r;
  logic [31:0] fwd_data_r;
  logic [TABLE_INDEX_BITS-1:0] idx, ld_idx;
  logic [31:0] entry;
  logic use_hash, hit, emit, fits, go, ld, wr_tbl;
  logic [2:0] kinc;

  assign go = s_valid_r && (!res_valid_r || res_ready);
  assign pkt_ready = !s_valid_r || go;
  assign ld = pkt_valid && pkt_ready;
  assign res_valid = res_valid_r;
  assign res = res_r;

  assign idx = s_pkt_r.hash_value[TABLE_INDEX_BITS-1:0];
  assign ld_idx = pkt.hash_value[TABLE_INDEX_BITS-1:0];
  // take the word written on the load edge when it hit the same entry
  assign entry = !vld_r[idx] ? 32'd0 : (fwd_r ? fwd_data_r : rd_r);

  always_comb begin
    use_hash = hash_en && (s_pkt_r.is_keyframe || !hash_key_only);
    hit = use_hash && (entry == s_pkt_r.hash_value);
    kinc = (kcnt_r < vnd_pkg::KEY_CNT_MAX) ? kcnt_r + 3'd1 : kcnt_r;
    fits = (25'(s_pkt_r.byte_count) + 25'(vnd_pkg::HDR_BYTES)) <= BUF;
    kcnt_nxt = kcnt_r;
    force_nxt = force_r;
    emit = 1'b0;
    wr_tbl = 1'b0;
    res_nxt.kind = vnd_pkg::KIND_DATA;
    res_nxt.slot = vnd_pkg::SLOT_NONE;
    res_nxt.prepend_headers = 1'b0;
    res_nxt.is_keyframe = 1'b0;
    res_nxt.packet_length = s_pkt_r.byte_count;
    res_nxt.hash_value = s_pkt_r.hash_value;
    if (s_pkt_r.is_short) begin
      res_nxt.kind = vnd_pkg::KIND_ERROR;
    end else begin
      res_nxt.is_keyframe = s_pkt_r.is_keyframe;
      if (use_hash) begin
        res_nxt.slot = 8'(32'(idx));
        if (hit) begin
          res_nxt.kind = vnd_pkg::KIND_REPLAY;
          res_nxt.packet_length = '0;
        end else begin
          wr_tbl = 1'b1;
        end
      end
      if (!hit && inject_en) begin
        if (force_r) begin
          emit = 1'b1;
        end else if (s_pkt_r.is_keyframe) begin
          kcnt_nxt = kinc;
          emit = kinc >= vnd_pkg::KEY_CNT_EMIT;
        end
        if (emit && fits) begin
          kcnt_nxt = '0;
          force_nxt = 1'b0;
          res_nxt.prepend_headers = 1'b1;
          res_nxt.packet_length =
            (s_pkt_r.byte_count > vnd_pkg::LEN_MAX - vnd_pkg::HDR_BYTES)
            ? vnd_pkg::LEN_MAX : s_pkt_r.byte_count + vnd_pkg::HDR_BYTES;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && !s_pkt_r.connect && wr_tbl) tbl_r[idx] <= s_pkt_r.hash_value;
    if (ld) rd_r <= tbl_r[ld_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      kcnt_r <= '0;
      force_r <= 1'b0;
      res_valid_r <= 1'b0;
      s_valid_r <= 1'b0;
      fwd_r <= 1'b0;
    end else begin
      if (res_valid_r && res_ready) res_valid_r <= 1'b0;
      if (ld) begin
        s_valid_r <= 1'b1;
        fwd_r <= go && !s_pkt_r.connect && wr_tbl && (idx == ld_idx);
      end else if (go) begin
        s_valid_r <= 1'b0;
      end
      if (go) begin
        if (s_pkt_r.connect) begin
          vld_r <= '0;
          force_r <= 1'b1;
        end else begin
          if (wr_tbl) vld_r[idx] <= 1'b1;
          kcnt_r <= kcnt_nxt;
          force_r <= force_nxt;
          res_valid_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      s_pkt_r <= pkt;
      fwd_data_r <= s_pkt_r.hash_value;
    end
    if (go && !s_pkt_r.connect) res_r <= res_nxt;
  end

  a_connect_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (go && s_pkt_r.connect && !res_valid_r) |=> !res_valid_r)
    else $error("result on connect");
  a_connect_force: assert property (@(posedge clk) disable iff (!rst_n)
    (go && s_pkt_r.connect) |=> force_r) else $error("force flag not set");
  a_prepend_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (go && !s_pkt_r.connect && res_nxt.prepend_headers) |=> (!force_r && kcnt_r == 3'd0))
    else $error("prepend did not clear counter");

endmodule

/* rtl/core/video_nal_dedup_and_header_inject_core.sv */
// Video packet duplicate filter with parameter-set prepend decision.
// in_*  : one word per packet byte (in_action=0) or a connect word (in_action=1).
//         in_last marks the final byte; the packet result follows it.
// out_* : one result word per packet: kind, slot, prepend flag, keyframe flag,
//         length to send and the packet CRC-32.
// cfg_* : write enable, index and data; write only while idle.
// Throughput: one input word per cycle while the queue has room. The front
// updates the CRC one byte a cycle; the back does one registered table read
// and at most one table write per packet. The last byte's packet word passes
// the queue, the lookup stage's table read and the result register in turn.
// A two-entry queue and the lookup stage sit between front and back; the
// result register frees as soon as the receiver takes it, so a stalled
// receiver holds off input only once the lookup stage and the queue fill.
// Reset clears the table, counter, force flag and packet state; registers
// return to enabled.
module video_nal_dedup_and_header_inject_core #(
  parameter int unsigned BUFFER_BYTES = vnd_pkg::BUFFER_BYTES_DEF,
  parameter int unsigned TABLE_INDEX_BITS = vnd_pkg::TABLE_INDEX_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  vnd_in_if.sink    in_ch,
  vnd_out_if.source out_ch,
  input logic       cfg_we,
  input logic [1:0] cfg_index,
  input logic       cfg_data
);

  logic hash_en_r, key_only_r, inject_en_r;
  logic f_valid, f_ready, q_valid, q_ready;
  vnd_pkg::pkt_t f_pkt, q_pkt;
  vnd_pkg::result_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_en_r <= 1'b1;
      key_only_r <= 1'b1;
      inject_en_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vnd_pkg::CFG_HASH_EN:       hash_en_r <= cfg_data;
        vnd_pkg::CFG_HASH_KEY_ONLY: key_only_r <= cfg_data;
        vnd_pkg::CFG_INJECT_EN:     inject_en_r <= cfg_data;
        default: ;
      endcase
    end
  end

  vnd_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_action(in_ch.action),
    .in_data_byte(in_ch.data_byte), .in_last(in_ch.last),
    .pkt_valid(f_valid), .pkt_ready(f_ready), .pkt(f_pkt)
  );

  vnd_queue u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_pkt),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_pkt)
  );

  vnd_back #(.BUFFER_BYTES(BUFFER_BYTES), .TABLE_INDEX_BITS(TABLE_INDEX_BITS)) u_back (
    .clk, .rst_n,
    .hash_en(hash_en_r), .hash_key_only(key_only_r), .inject_en(inject_en_r),
    .pkt_valid(q_valid), .pkt_ready(q_ready), .pkt(q_pkt),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(res)
  );

  assign out_ch.kind = res.kind;
  assign out_ch.slot = res.slot;
  assign out_ch.prepend_headers = res.prepend_headers;
  assign out_ch.is_keyframe = res.is_keyframe;
  assign out_ch.packet_length = res.packet_length;
  assign out_ch.hash_value = res.hash_value;

endmodule
